@@ rtl/core/cnsf_pkg.sv @@
// Shared types, constants and pipeline timing for the 2D compressible flux point unit.
// Used by every module of the block but cnsf_dly, and by the port checker.
package cnsf_pkg;

    localparam int QW = 48;

    typedef logic signed [QW-1:0] q_t;
    typedef logic [31:0] coef_t;
    typedef logic [1:0]  cfg_idx_t;

    // Register map of the configuration channel.
    localparam cfg_idx_t REG_GAMMA_M1 = 2'd0;
    localparam cfg_idx_t REG_VISCOSITY = 2'd1;
    localparam cfg_idx_t REG_HEAT_COEF = 2'd2;

    localparam coef_t GAMMA_M1_RST = 32'd6710886;
    localparam coef_t VISCOSITY_RST = 32'd838861;
    localparam coef_t HEAT_COEF_RST = 32'd1631118;

    localparam q_t Q_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam q_t Q_MIN = 48'sh8000_0000_0000;
    localparam q_t Q_HALF = 48'sd8388608;
    localparam q_t Q_TWO_THIRDS = 48'sd11184811;

    // Operator latencies in cycles.
    localparam int MUL_LAT = 3;
    localparam int DIV_STEPS = 36;
    localparam int DIV_LAT = DIV_STEPS + 1;
    localparam int ADD_LAT = 1;

    // Ready times of the intermediate values, counted from the input register.
    localparam int T_UV = DIV_LAT;
    localparam int T_P1 = T_UV + MUL_LAT;
    localparam int T_A1 = T_P1 + ADD_LAT;
    localparam int T_KE = T_A1 + MUL_LAT;
    localparam int T_G = T_A1 + DIV_LAT;
    localparam int T_EK = T_KE + ADD_LAT;
    localparam int T_P = T_EK + MUL_LAT;
    localparam int T_EI = T_EK + DIV_LAT;
    localparam int T_HV = T_KE + MUL_LAT;
    localparam int T_PA = T_P + ADD_LAT;
    localparam int T_IE = T_PA + MUL_LAT;
    localparam int T_GA = T_G + ADD_LAT;
    localparam int T_GM = T_G + MUL_LAT;
    localparam int T_MU = T_GA + MUL_LAT;
    localparam int T_CO = T_MU + MUL_LAT;
    localparam int T_S = T_CO + ADD_LAT;
    localparam int T_KA = T_GM + ADD_LAT;
    localparam int T_KR = T_KA + MUL_LAT;
    localparam int T_KG = T_KR + ADD_LAT;
    localparam int T_E1 = T_KG + ADD_LAT;
    localparam int T_RE = T_EI + MUL_LAT;
    localparam int T_IN = T_E1 + ADD_LAT;
    localparam int T_IG = T_IN + DIV_LAT;
    localparam int T_HG = T_IG + MUL_LAT;
    localparam int T_US = T_S + MUL_LAT;
    localparam int T_SA = T_US + ADD_LAT;
    localparam int T_F = T_HG + ADD_LAT;

    // Clock edges from the accepting edge to the edge that takes the result.
    localparam int PIPE_LAT = T_F + 2;

    // Turns a rounded magnitude and a sign into a saturated Q23.24 value.
    function automatic q_t sat_mag(input logic [72:0] m, input logic neg);
        q_t res;
        if (neg) begin
            if (m > 73'h0_8000_0000_0000) begin
                res = Q_MIN;
            end
            else begin
                res = q_t'(-m[47:0]);
            end
        end
        else begin
            if (m > 73'h0_7FFF_FFFF_FFFF) begin
                res = Q_MAX;
            end
            else begin
                res = q_t'(m[47:0]);
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/core/cnsf_dly.sv @@
// Fixed-length delay line that aligns operands between pipeline branches.
// Depends on nothing; width and depth come from its parameters.
module cnsf_dly #(
    parameter int W = 48,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    generate
        if (N == 0) begin : g_none
            assign q = d;
        end
        else begin : g_line
            logic [W-1:0] pipe_reg [N];

            // Shift one slot per cycle.
            always_ff @(posedge clk)
            begin
                pipe_reg[0] <= d;
                for (int i = 1; i < N; i++)
                begin
                    pipe_reg[i] <= pipe_reg[i-1];
                end
            end

            assign q = pipe_reg[N-1];
        end
    endgenerate

endmodule

@@ rtl/core/cnsf_add.sv @@
// Registered saturating add or subtract of two Q23.24 values.
// Depends on cnsf_pkg.
module cnsf_add (
    input  logic           clk,
    input  cnsf_pkg::q_t   a,
    input  cnsf_pkg::q_t   b,
    input  logic           sub,
    output cnsf_pkg::q_t   s
);
    import cnsf_pkg::*;

    logic signed [QW:0] sum;
    q_t                 s_reg;
    q_t                 s_next;

    // Exact sum one bit wider, then clamp.
    always_comb
    begin
        if (sub) begin
            sum = (QW+1)'(a) - (QW+1)'(b);
        end
        else begin
            sum = (QW+1)'(a) + (QW+1)'(b);
        end
        if (sum[QW] != sum[QW-1]) begin
            s_next = sum[QW] ? Q_MIN : Q_MAX;
        end
        else begin
            s_next = sum[QW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

    assign s = s_reg;

endmodule

@@ rtl/core/cnsf_mul.sv @@
// Three-stage Q23.24 multiplier: 24x24 partial products, sum and round, saturate.
// Depends on cnsf_pkg.
module cnsf_mul (
    input  logic         clk,
    input  cnsf_pkg::q_t a,
    input  cnsf_pkg::q_t b,
    output cnsf_pkg::q_t p
);
    import cnsf_pkg::*;

    logic [47:0] am;
    logic [47:0] bm;
    logic [47:0] p00_reg;
    logic [47:0] p01_reg;
    logic [47:0] p10_reg;
    logic [47:0] p11_reg;
    logic        neg1_reg;
    logic [48:0] mid;
    logic [96:0] sum2;
    logic [72:0] mag2_reg;
    logic        neg2_reg;
    q_t          p_reg;

    assign am = a[QW-1] ? 48'(-a) : 48'(a);
    assign bm = b[QW-1] ? 48'(-b) : 48'(b);

    // Stage one: four narrow partial products of the magnitudes.
    always_ff @(posedge clk)
    begin
        p00_reg  <= am[23:0] * bm[23:0];
        p01_reg  <= am[23:0] * bm[47:24];
        p10_reg  <= am[47:24] * bm[23:0];
        p11_reg  <= am[47:24] * bm[47:24];
        neg1_reg <= a[QW-1] ^ b[QW-1];
    end

    // Stage two: full product plus half an LSB, scaled down by 2^24.
    assign mid  = 49'(p01_reg) + 49'(p10_reg);
    assign sum2 = 97'(p00_reg) + (97'(mid) << 24) + (97'(p11_reg) << 48) + 97'(24'h80_0000);

    always_ff @(posedge clk)
    begin
        mag2_reg <= sum2[96:24];
        neg2_reg <= neg1_reg;
    end

    // Stage three: sign and saturation.
    always_ff @(posedge clk)
    begin
        p_reg <= sat_mag(mag2_reg, neg2_reg);
    end

    assign p = p_reg;

endmodule

@@ rtl/core/cnsf_div.sv @@
// Pipelined restoring divider for a Q23.24 value over a positive Q23.24 divisor.
// Two quotient bits per stage, then a round and saturate stage; depends on cnsf_pkg.
module cnsf_div (
    input  logic         clk,
    input  cnsf_pkg::q_t a,
    input  cnsf_pkg::q_t b,
    output cnsf_pkg::q_t q
);
    import cnsf_pkg::*;

    logic [71:0] num_reg [DIV_STEPS];
    logic [71:0] quo_reg [DIV_STEPS];
    logic [47:0] rem_reg [DIV_STEPS];
    logic [47:0] den_reg [DIV_STEPS];
    logic        neg_reg [DIV_STEPS];

    logic [47:0] nmag;
    q_t          q_reg;
    logic [48:0] rem_fin;
    logic [48:0] gap_fin;
    logic [72:0] qr_fin;

    assign nmag = a[QW-1] ? 48'(-a) : 48'(a);

    // One stage per two quotient bits.
    generate
        for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
            logic [71:0] num_in;
            logic [71:0] quo_in;
            logic [47:0] rem_in;
            logic [47:0] den_in;
            logic        neg_in;
            logic [48:0] r1;
            logic [48:0] r2;
            logic [47:0] r1s;
            logic        qb1;
            logic        qb2;

            if (k == 0) begin : g_first
                assign num_in = {nmag, 24'd0};
                assign quo_in = '0;
                assign rem_in = '0;
                assign den_in = 48'(b);
                assign neg_in = a[QW-1];
            end
            else begin : g_next
                assign num_in = num_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign neg_in = neg_reg[k-1];
            end

            // Two shift and compare-subtract steps.
            always_comb
            begin
                r1  = {rem_in, num_in[71]};
                qb1 = (r1 >= {1'b0, den_in});
                r1s = qb1 ? 48'(r1 - {1'b0, den_in}) : r1[47:0];
                r2  = {r1s, num_in[70]};
                qb2 = (r2 >= {1'b0, den_in});
            end

            always_ff @(posedge clk)
            begin
                num_reg[k] <= {num_in[69:0], 2'b00};
                quo_reg[k] <= {quo_in[69:0], qb1, qb2};
                rem_reg[k] <= qb2 ? 48'(r2 - {1'b0, den_in}) : r2[47:0];
                den_reg[k] <= den_in;
                neg_reg[k] <= neg_in;
            end
        end
    endgenerate

    // Round to nearest, ties away from zero, then saturate.
    assign rem_fin = {1'b0, rem_reg[DIV_STEPS-1]};
    assign gap_fin = {1'b0, den_reg[DIV_STEPS-1]} - rem_fin;
    assign qr_fin  = {1'b0, quo_reg[DIV_STEPS-1]} + 73'(rem_fin >= gap_fin);

    always_ff @(posedge clk)
    begin
        q_reg <= sat_mag(qr_fin, neg_reg[DIV_STEPS-1]);
    end

    assign q = q_reg;

endmodule

@@ rtl/core/compressible_ns_point_flux_2d.sv @@
// Top level of the 2D compressible Navier-Stokes point flux pipeline.
// Depends on cnsf_pkg, cnsf_dly, cnsf_add, cnsf_mul and cnsf_div.
//
// Usage:
//   Input channel: drive the twelve state and gradient fields and pulse start.
//   An item is taken on every rising edge with start high and busy low; busy
//   stays low, so a new point can enter in every cycle.
//   Result channel: result_valid is high for exactly one cycle with the ten
//   flux terms and bad_density. The receiver cannot hold results off.
//   Result timing: PIPE_LAT counts the clock edges from the accepting edge to the edge
//   that takes the result. The longest path is the chain of three dividers
//   (velocity, velocity gradient, internal-energy gradient), each with two
//   quotient bits per stage, plus the multipliers and adders between them.
//   Throughput: one point per cycle, sustained.
//   Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write one of three
//   Q8.24 coefficients; cfg_ready is always high. Write only while idle.
//   Reset: rst_n clears the valid pipeline and restores the coefficients;
//   no result is produced for items in flight at reset.
module compressible_ns_point_flux_2d (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cnsf_pkg::q_t        density,
    input  cnsf_pkg::q_t        mom_x,
    input  cnsf_pkg::q_t        mom_y,
    input  cnsf_pkg::q_t        total_energy,
    input  cnsf_pkg::q_t        density_dx,
    input  cnsf_pkg::q_t        density_dy,
    input  cnsf_pkg::q_t        mom_x_dx,
    input  cnsf_pkg::q_t        mom_x_dy,
    input  cnsf_pkg::q_t        mom_y_dx,
    input  cnsf_pkg::q_t        mom_y_dy,
    input  cnsf_pkg::q_t        energy_dx,
    input  cnsf_pkg::q_t        energy_dy,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  cnsf_pkg::cfg_idx_t  cfg_index,
    input  cnsf_pkg::coef_t     cfg_data,
    output logic                result_valid,
    output cnsf_pkg::q_t        inv_xx,
    output cnsf_pkg::q_t        inv_xy,
    output cnsf_pkg::q_t        inv_yy,
    output cnsf_pkg::q_t        inv_energy_x,
    output cnsf_pkg::q_t        inv_energy_y,
    output cnsf_pkg::q_t        stress_xx,
    output cnsf_pkg::q_t        stress_xy,
    output cnsf_pkg::q_t        stress_yy,
    output cnsf_pkg::q_t        vis_energy_x,
    output cnsf_pkg::q_t        vis_energy_y,
    output logic                bad_density
);
    import cnsf_pkg::*;

    // Configuration registers.
    coef_t g1_reg;
    coef_t mu_reg;
    coef_t hc_reg;
    q_t    g1;
    q_t    mu;
    q_t    hc;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            g1_reg <= GAMMA_M1_RST;
            mu_reg <= VISCOSITY_RST;
            hc_reg <= HEAT_COEF_RST;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_GAMMA_M1:  g1_reg <= cfg_data;
                REG_VISCOSITY: mu_reg <= cfg_data;
                REG_HEAT_COEF: hc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign g1 = q_t'({16'd0, g1_reg});
    assign mu = q_t'({16'd0, mu_reg});
    assign hc = q_t'({16'd0, hc_reg});

    // Input register.
    q_t   rho_reg;
    q_t   mx_reg;
    q_t   my_reg;
    q_t   en_reg;
    q_t   rdx_reg;
    q_t   rdy_reg;
    q_t   mxdx_reg;
    q_t   mxdy_reg;
    q_t   mydx_reg;
    q_t   mydy_reg;
    q_t   edx_reg;
    q_t   edy_reg;
    logic in_vld_reg;

    always_ff @(posedge clk)
    begin
        rho_reg  <= density;
        mx_reg   <= mom_x;
        my_reg   <= mom_y;
        en_reg   <= total_energy;
        rdx_reg  <= density_dx;
        rdy_reg  <= density_dy;
        mxdx_reg <= mom_x_dx;
        mxdy_reg <= mom_x_dy;
        mydx_reg <= mom_y_dx;
        mydy_reg <= mom_y_dy;
        edx_reg  <= energy_dx;
        edy_reg  <= energy_dy;
    end

    // Valid bits travel alongside the data.
    logic [T_F-1:0] vld_pipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg   <= 1'b0;
            vld_pipe_reg <= '0;
        end
        else begin
            in_vld_reg   <= start && !busy;
            vld_pipe_reg <= {vld_pipe_reg[T_F-2:0], in_vld_reg};
        end
    end

    logic bad0;
    logic bad_f;
    assign bad0 = rho_reg[QW-1] || (rho_reg == '0);
    cnsf_dly #(.W(1), .N(T_F)) u_d_bad (.clk(clk), .d(bad0), .q(bad_f));

    // Operand alignment for the input values.
    q_t rho_uv, rho_a1, rho_ek, rho_ka, rho_in;
    q_t mx_uv, my_uv, en_ke, en_p;
    q_t rdx_uv, rdy_uv, rdx_a1, rdy_a1, rdx_ei, rdy_ei;
    q_t mxdx_p1, mxdy_p1, mydx_p1, mydy_p1, edx_kg, edy_kg;

    cnsf_dly #(.W(QW), .N(T_UV)) u_d_rho0 (.clk(clk), .d(rho_reg), .q(rho_uv));
    cnsf_dly #(.W(QW), .N(T_A1 - T_UV)) u_d_rho1 (.clk(clk), .d(rho_uv), .q(rho_a1));
    cnsf_dly #(.W(QW), .N(T_EK - T_A1)) u_d_rho2 (.clk(clk), .d(rho_a1), .q(rho_ek));
    cnsf_dly #(.W(QW), .N(T_KA - T_EK)) u_d_rho3 (.clk(clk), .d(rho_ek), .q(rho_ka));
    cnsf_dly #(.W(QW), .N(T_IN - T_KA)) u_d_rho4 (.clk(clk), .d(rho_ka), .q(rho_in));
    cnsf_dly #(.W(QW), .N(T_UV)) u_d_mx (.clk(clk), .d(mx_reg), .q(mx_uv));
    cnsf_dly #(.W(QW), .N(T_UV)) u_d_my (.clk(clk), .d(my_reg), .q(my_uv));
    cnsf_dly #(.W(QW), .N(T_KE)) u_d_en0 (.clk(clk), .d(en_reg), .q(en_ke));
    cnsf_dly #(.W(QW), .N(T_P - T_KE)) u_d_en1 (.clk(clk), .d(en_ke), .q(en_p));
    cnsf_dly #(.W(QW), .N(T_UV)) u_d_rdx0 (.clk(clk), .d(rdx_reg), .q(rdx_uv));
    cnsf_dly #(.W(QW), .N(T_UV)) u_d_rdy0 (.clk(clk), .d(rdy_reg), .q(rdy_uv));
    cnsf_dly #(.W(QW), .N(T_A1 - T_UV)) u_d_rdx1 (.clk(clk), .d(rdx_uv), .q(rdx_a1));
    cnsf_dly #(.W(QW), .N(T_A1 - T_UV)) u_d_rdy1 (.clk(clk), .d(rdy_uv), .q(rdy_a1));
    cnsf_dly #(.W(QW), .N(T_EI - T_A1)) u_d_rdx2 (.clk(clk), .d(rdx_a1), .q(rdx_ei));
    cnsf_dly #(.W(QW), .N(T_EI - T_A1)) u_d_rdy2 (.clk(clk), .d(rdy_a1), .q(rdy_ei));
    cnsf_dly #(.W(QW), .N(T_P1)) u_d_mxdx (.clk(clk), .d(mxdx_reg), .q(mxdx_p1));
    cnsf_dly #(.W(QW), .N(T_P1)) u_d_mxdy (.clk(clk), .d(mxdy_reg), .q(mxdy_p1));
    cnsf_dly #(.W(QW), .N(T_P1)) u_d_mydx (.clk(clk), .d(mydx_reg), .q(mydx_p1));
    cnsf_dly #(.W(QW), .N(T_P1)) u_d_mydy (.clk(clk), .d(mydy_reg), .q(mydy_p1));
    cnsf_dly #(.W(QW), .N(T_KG)) u_d_edx (.clk(clk), .d(edx_reg), .q(edx_kg));
    cnsf_dly #(.W(QW), .N(T_KG)) u_d_edy (.clk(clk), .d(edy_reg), .q(edy_kg));

    // Velocity.
    q_t u, v, u_pa, v_pa, u_g, v_g, u_s, v_s;
    cnsf_div u_div_u (.clk(clk), .a(mx_reg), .b(rho_reg), .q(u));
    cnsf_div u_div_v (.clk(clk), .a(my_reg), .b(rho_reg), .q(v));
    cnsf_dly #(.W(QW), .N(T_PA - T_UV)) u_d_u0 (.clk(clk), .d(u), .q(u_pa));
    cnsf_dly #(.W(QW), .N(T_PA - T_UV)) u_d_v0 (.clk(clk), .d(v), .q(v_pa));
    cnsf_dly #(.W(QW), .N(T_G - T_PA)) u_d_u1 (.clk(clk), .d(u_pa), .q(u_g));
    cnsf_dly #(.W(QW), .N(T_G - T_PA)) u_d_v1 (.clk(clk), .d(v_pa), .q(v_g));
    cnsf_dly #(.W(QW), .N(T_S - T_G)) u_d_u2 (.clk(clk), .d(u_g), .q(u_s));
    cnsf_dly #(.W(QW), .N(T_S - T_G)) u_d_v2 (.clk(clk), .d(v_g), .q(v_s));

    // Products of the velocity.
    q_t uu, vv, hr, mxu, mxv, myv, rdxu, rdyu, rdxv, rdyv;
    cnsf_mul u_m_uu (.clk(clk), .a(u), .b(u), .p(uu));
    cnsf_mul u_m_vv (.clk(clk), .a(v), .b(v), .p(vv));
    cnsf_mul u_m_hr (.clk(clk), .a(Q_HALF), .b(rho_uv), .p(hr));
    cnsf_mul u_m_mxu (.clk(clk), .a(mx_uv), .b(u), .p(mxu));
    cnsf_mul u_m_mxv (.clk(clk), .a(mx_uv), .b(v), .p(mxv));
    cnsf_mul u_m_myv (.clk(clk), .a(my_uv), .b(v), .p(myv));
    cnsf_mul u_m_rdxu (.clk(clk), .a(rdx_uv), .b(u), .p(rdxu));
    cnsf_mul u_m_rdyu (.clk(clk), .a(rdy_uv), .b(u), .p(rdyu));
    cnsf_mul u_m_rdxv (.clk(clk), .a(rdx_uv), .b(v), .p(rdxv));
    cnsf_mul u_m_rdyv (.clk(clk), .a(rdy_uv), .b(v), .p(rdyv));

    // Speed squared and velocity gradient numerators.
    q_t vsq, nxx, nxy, nyx, nyy, hr_a1;
    cnsf_add u_a_vsq (.clk(clk), .a(uu), .b(vv), .sub(1'b0), .s(vsq));
    cnsf_add u_a_nxx (.clk(clk), .a(mxdx_p1), .b(rdxu), .sub(1'b1), .s(nxx));
    cnsf_add u_a_nxy (.clk(clk), .a(mxdy_p1), .b(rdyu), .sub(1'b1), .s(nxy));
    cnsf_add u_a_nyx (.clk(clk), .a(mydx_p1), .b(rdxv), .sub(1'b1), .s(nyx));
    cnsf_add u_a_nyy (.clk(clk), .a(mydy_p1), .b(rdyv), .sub(1'b1), .s(nyy));
    cnsf_dly #(.W(QW), .N(T_A1 - T_P1)) u_d_hr (.clk(clk), .d(hr), .q(hr_a1));

    // Kinetic energy, pressure and internal energy.
    q_t ke, vrx, vry, ek, p, eint, hvx, hvy;
    cnsf_mul u_m_ke (.clk(clk), .a(hr_a1), .b(vsq), .p(ke));
    cnsf_mul u_m_vrx (.clk(clk), .a(vsq), .b(rdx_a1), .p(vrx));
    cnsf_mul u_m_vry (.clk(clk), .a(vsq), .b(rdy_a1), .p(vry));
    cnsf_add u_a_ek (.clk(clk), .a(en_ke), .b(ke), .sub(1'b1), .s(ek));
    cnsf_mul u_m_p (.clk(clk), .a(ek), .b(g1), .p(p));
    cnsf_div u_div_ei (.clk(clk), .a(ek), .b(rho_ek), .q(eint));
    cnsf_mul u_m_hvx (.clk(clk), .a(Q_HALF), .b(vrx), .p(hvx));
    cnsf_mul u_m_hvy (.clk(clk), .a(Q_HALF), .b(vry), .p(hvy));

    // Inviscid flux terms.
    q_t mxu_p, myv_p, ep, ixx, iyy, iex, iey;
    cnsf_dly #(.W(QW), .N(T_P - T_P1)) u_d_mxu (.clk(clk), .d(mxu), .q(mxu_p));
    cnsf_dly #(.W(QW), .N(T_P - T_P1)) u_d_myv (.clk(clk), .d(myv), .q(myv_p));
    cnsf_add u_a_ep (.clk(clk), .a(en_p), .b(p), .sub(1'b0), .s(ep));
    cnsf_add u_a_ixx (.clk(clk), .a(mxu_p), .b(p), .sub(1'b0), .s(ixx));
    cnsf_add u_a_iyy (.clk(clk), .a(myv_p), .b(p), .sub(1'b0), .s(iyy));
    cnsf_mul u_m_iex (.clk(clk), .a(ep), .b(u_pa), .p(iex));
    cnsf_mul u_m_iey (.clk(clk), .a(ep), .b(v_pa), .p(iey));

    // Velocity gradients.
    q_t gxx, gxy, gyx, gyy;
    cnsf_div u_div_gxx (.clk(clk), .a(nxx), .b(rho_a1), .q(gxx));
    cnsf_div u_div_gxy (.clk(clk), .a(nxy), .b(rho_a1), .q(gxy));
    cnsf_div u_div_gyx (.clk(clk), .a(nyx), .b(rho_a1), .q(gyx));
    cnsf_div u_div_gyy (.clk(clk), .a(nyy), .b(rho_a1), .q(gyy));

    // Viscous stress.
    q_t gs, g2x, g2y, gc, mgs, m2x, m2y, sxy_mu, m2x_co, m2y_co, corr;
    q_t sxx, syy, sxy;
    cnsf_add u_a_gs (.clk(clk), .a(gxx), .b(gyy), .sub(1'b0), .s(gs));
    cnsf_add u_a_g2x (.clk(clk), .a(gxx), .b(gxx), .sub(1'b0), .s(g2x));
    cnsf_add u_a_g2y (.clk(clk), .a(gyy), .b(gyy), .sub(1'b0), .s(g2y));
    cnsf_add u_a_gc (.clk(clk), .a(gxy), .b(gyx), .sub(1'b0), .s(gc));
    cnsf_mul u_m_mgs (.clk(clk), .a(mu), .b(gs), .p(mgs));
    cnsf_mul u_m_m2x (.clk(clk), .a(mu), .b(g2x), .p(m2x));
    cnsf_mul u_m_m2y (.clk(clk), .a(mu), .b(g2y), .p(m2y));
    cnsf_mul u_m_sxy (.clk(clk), .a(mu), .b(gc), .p(sxy_mu));
    cnsf_mul u_m_corr (.clk(clk), .a(mgs), .b(Q_TWO_THIRDS), .p(corr));
    cnsf_dly #(.W(QW), .N(T_CO - T_MU)) u_d_m2x (.clk(clk), .d(m2x), .q(m2x_co));
    cnsf_dly #(.W(QW), .N(T_CO - T_MU)) u_d_m2y (.clk(clk), .d(m2y), .q(m2y_co));
    cnsf_add u_a_sxx (.clk(clk), .a(m2x_co), .b(corr), .sub(1'b1), .s(sxx));
    cnsf_add u_a_syy (.clk(clk), .a(m2y_co), .b(corr), .sub(1'b1), .s(syy));
    cnsf_dly #(.W(QW), .N(T_S - T_MU)) u_d_sxy (.clk(clk), .d(sxy_mu), .q(sxy));

    // Gradient of the kinetic energy.
    q_t gxu, gyxv, gxyu, gyyv, ka, kb, kra, krb, hvx_kr, hvy_kr, kgx, kgy;
    cnsf_mul u_m_gxu (.clk(clk), .a(gxx), .b(u_g), .p(gxu));
    cnsf_mul u_m_gyxv (.clk(clk), .a(gyx), .b(v_g), .p(gyxv));
    cnsf_mul u_m_gxyu (.clk(clk), .a(gxy), .b(u_g), .p(gxyu));
    cnsf_mul u_m_gyyv (.clk(clk), .a(gyy), .b(v_g), .p(gyyv));
    cnsf_add u_a_ka (.clk(clk), .a(gxu), .b(gyxv), .sub(1'b0), .s(ka));
    cnsf_add u_a_kb (.clk(clk), .a(gxyu), .b(gyyv), .sub(1'b0), .s(kb));
    cnsf_mul u_m_kra (.clk(clk), .a(rho_ka), .b(ka), .p(kra));
    cnsf_mul u_m_krb (.clk(clk), .a(rho_ka), .b(kb), .p(krb));
    cnsf_dly #(.W(QW), .N(T_KR - T_HV)) u_d_hvx (.clk(clk), .d(hvx), .q(hvx_kr));
    cnsf_dly #(.W(QW), .N(T_KR - T_HV)) u_d_hvy (.clk(clk), .d(hvy), .q(hvy_kr));
    cnsf_add u_a_kgx (.clk(clk), .a(hvx_kr), .b(kra), .sub(1'b0), .s(kgx));
    cnsf_add u_a_kgy (.clk(clk), .a(hvy_kr), .b(krb), .sub(1'b0), .s(kgy));

    // Gradient of the internal energy.
    q_t e1x, e1y, rdex, rdey, rdex_e1, rdey_e1, inx, iny, igx, igy, hgx, hgy;
    cnsf_add u_a_e1x (.clk(clk), .a(edx_kg), .b(kgx), .sub(1'b1), .s(e1x));
    cnsf_add u_a_e1y (.clk(clk), .a(edy_kg), .b(kgy), .sub(1'b1), .s(e1y));
    cnsf_mul u_m_rdex (.clk(clk), .a(rdx_ei), .b(eint), .p(rdex));
    cnsf_mul u_m_rdey (.clk(clk), .a(rdy_ei), .b(eint), .p(rdey));
    cnsf_dly #(.W(QW), .N(T_E1 - T_RE)) u_d_rdex (.clk(clk), .d(rdex), .q(rdex_e1));
    cnsf_dly #(.W(QW), .N(T_E1 - T_RE)) u_d_rdey (.clk(clk), .d(rdey), .q(rdey_e1));
    cnsf_add u_a_inx (.clk(clk), .a(e1x), .b(rdex_e1), .sub(1'b1), .s(inx));
    cnsf_add u_a_iny (.clk(clk), .a(e1y), .b(rdey_e1), .sub(1'b1), .s(iny));
    cnsf_div u_div_igx (.clk(clk), .a(inx), .b(rho_in), .q(igx));
    cnsf_div u_div_igy (.clk(clk), .a(iny), .b(rho_in), .q(igy));
    cnsf_mul u_m_hgx (.clk(clk), .a(hc), .b(igx), .p(hgx));
    cnsf_mul u_m_hgy (.clk(clk), .a(hc), .b(igy), .p(hgy));

    // Work of the viscous stress.
    q_t usxx, vsxy, usxy, vsyy, swx, swy, swx_hg, swy_hg, vex, vey;
    cnsf_mul u_m_usxx (.clk(clk), .a(u_s), .b(sxx), .p(usxx));
    cnsf_mul u_m_vsxy (.clk(clk), .a(v_s), .b(sxy), .p(vsxy));
    cnsf_mul u_m_usxy (.clk(clk), .a(u_s), .b(sxy), .p(usxy));
    cnsf_mul u_m_vsyy (.clk(clk), .a(v_s), .b(syy), .p(vsyy));
    cnsf_add u_a_swx (.clk(clk), .a(usxx), .b(vsxy), .sub(1'b0), .s(swx));
    cnsf_add u_a_swy (.clk(clk), .a(usxy), .b(vsyy), .sub(1'b0), .s(swy));
    cnsf_dly #(.W(QW), .N(T_HG - T_SA)) u_d_swx (.clk(clk), .d(swx), .q(swx_hg));
    cnsf_dly #(.W(QW), .N(T_HG - T_SA)) u_d_swy (.clk(clk), .d(swy), .q(swy_hg));
    cnsf_add u_a_vex (.clk(clk), .a(hgx), .b(swx_hg), .sub(1'b0), .s(vex));
    cnsf_add u_a_vey (.clk(clk), .a(hgy), .b(swy_hg), .sub(1'b0), .s(vey));

    // Align the early results with the last ones.
    q_t ixx_f, ixy_f, iyy_f, iex_f, iey_f, sxx_f, sxy_f, syy_f;
    cnsf_dly #(.W(QW), .N(T_F - T_PA)) u_d_oxx (.clk(clk), .d(ixx), .q(ixx_f));
    cnsf_dly #(.W(QW), .N(T_F - T_P1)) u_d_oxy (.clk(clk), .d(mxv), .q(ixy_f));
    cnsf_dly #(.W(QW), .N(T_F - T_PA)) u_d_oyy (.clk(clk), .d(iyy), .q(iyy_f));
    cnsf_dly #(.W(QW), .N(T_F - T_IE)) u_d_oex (.clk(clk), .d(iex), .q(iex_f));
    cnsf_dly #(.W(QW), .N(T_F - T_IE)) u_d_oey (.clk(clk), .d(iey), .q(iey_f));
    cnsf_dly #(.W(QW), .N(T_F - T_S)) u_d_osxx (.clk(clk), .d(sxx), .q(sxx_f));
    cnsf_dly #(.W(QW), .N(T_F - T_S)) u_d_osxy (.clk(clk), .d(sxy), .q(sxy_f));
    cnsf_dly #(.W(QW), .N(T_F - T_S)) u_d_osyy (.clk(clk), .d(syy), .q(syy_f));

    // Output register; a bad density clears every flux term.
    logic result_valid_reg;
    q_t   inv_xx_reg, inv_xy_reg, inv_yy_reg, inv_energy_x_reg, inv_energy_y_reg;
    q_t   stress_xx_reg, stress_xy_reg, stress_yy_reg, vis_energy_x_reg, vis_energy_y_reg;
    logic bad_density_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end
        else begin
            result_valid_reg <= vld_pipe_reg[T_F-1];
        end
    end

    always_ff @(posedge clk)
    begin
        bad_density_reg  <= bad_f;
        inv_xx_reg       <= bad_f ? '0 : ixx_f;
        inv_xy_reg       <= bad_f ? '0 : ixy_f;
        inv_yy_reg       <= bad_f ? '0 : iyy_f;
        inv_energy_x_reg <= bad_f ? '0 : iex_f;
        inv_energy_y_reg <= bad_f ? '0 : iey_f;
        stress_xx_reg    <= bad_f ? '0 : sxx_f;
        stress_xy_reg    <= bad_f ? '0 : sxy_f;
        stress_yy_reg    <= bad_f ? '0 : syy_f;
        vis_energy_x_reg <= bad_f ? '0 : vex;
        vis_energy_y_reg <= bad_f ? '0 : vey;
    end

    assign result_valid = result_valid_reg;
    assign inv_xx       = inv_xx_reg;
    assign inv_xy       = inv_xy_reg;
    assign inv_yy       = inv_yy_reg;
    assign inv_energy_x = inv_energy_x_reg;
    assign inv_energy_y = inv_energy_y_reg;
    assign stress_xx    = stress_xx_reg;
    assign stress_xy    = stress_xy_reg;
    assign stress_yy    = stress_yy_reg;
    assign vis_energy_x = vis_energy_x_reg;
    assign vis_energy_y = vis_energy_y_reg;
    assign bad_density  = bad_density_reg;

endmodule

@@ rtl/core/cnsf_chk.sv @@
// Port-level checker for the point flux pipeline, bound to the top level.
// Depends on cnsf_pkg for the pipeline latency.
module cnsf_chk (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  cnsf_pkg::q_t        density,
    input  cnsf_pkg::q_t        mom_x,
    input  cnsf_pkg::q_t        mom_y,
    input  cnsf_pkg::q_t        total_energy,
    input  cnsf_pkg::q_t        density_dx,
    input  cnsf_pkg::q_t        density_dy,
    input  cnsf_pkg::q_t        mom_x_dx,
    input  cnsf_pkg::q_t        mom_x_dy,
    input  cnsf_pkg::q_t        mom_y_dx,
    input  cnsf_pkg::q_t        mom_y_dy,
    input  cnsf_pkg::q_t        energy_dx,
    input  cnsf_pkg::q_t        energy_dy,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  cnsf_pkg::cfg_idx_t  cfg_index,
    input  cnsf_pkg::coef_t     cfg_data,
    input  logic                result_valid,
    input  cnsf_pkg::q_t        inv_xx,
    input  cnsf_pkg::q_t        inv_xy,
    input  cnsf_pkg::q_t        inv_yy,
    input  cnsf_pkg::q_t        inv_energy_x,
    input  cnsf_pkg::q_t        inv_energy_y,
    input  cnsf_pkg::q_t        stress_xx,
    input  cnsf_pkg::q_t        stress_xy,
    input  cnsf_pkg::q_t        stress_yy,
    input  cnsf_pkg::q_t        vis_energy_x,
    input  cnsf_pkg::q_t        vis_energy_y,
    input  logic                bad_density
);
    import cnsf_pkg::*;

    localparam int CW = $clog2(PIPE_LAT + 1);

    // Edges since reset release, saturating once a full pipeline has passed.
    logic [CW-1:0] up_cnt_reg;
    logic          warm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            up_cnt_reg <= '0;
        end
        else if (up_cnt_reg != CW'(PIPE_LAT)) begin
            up_cnt_reg <= up_cnt_reg + CW'(1);
        end
    end

    assign warm = (up_cnt_reg == CW'(PIPE_LAT));

    // Every accepted beat yields a result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && $past(start && !busy, PIPE_LAT)) |-> result_valid)
        else $error("accepted beat produced no result");

    // No result appears without a matching accepted beat.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (warm && $past(start && !busy, PIPE_LAT)))
        else $error("result without an accepted beat");

    // A bad density clears the flux terms.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && bad_density) |->
            (inv_xx == '0 && inv_xy == '0 && inv_yy == '0 && inv_energy_x == '0 &&
             inv_energy_y == '0 && stress_xx == '0 && stress_xy == '0 &&
             stress_yy == '0 && vis_energy_x == '0 && vis_energy_y == '0))
        else $error("flux terms not cleared on bad density");

endmodule

bind compressible_ns_point_flux_2d cnsf_chk u_cnsf_chk (.*);

@@ verif/compressible_ns_point_flux_2d_tb.sv @@
// Self-checking testbench for the 2D compressible Navier-Stokes point flux unit.
// Depends on cnsf_pkg and compressible_ns_point_flux_2d; a fixed-point predictor or a typed
// directed row gives each expected flux beat, compared field by field with the result port.
module compressible_ns_point_flux_2d_tb;

    import cnsf_pkg::*;

    // Index that maps to no coefficient; writes to it must be ignored.
    localparam cfg_idx_t REG_NONE = 2'd3;
    localparam int NUM_FLUX = 10;
    localparam int QUIET_FIRST = 300;
    localparam int QUIET_LAST = 550;
    localparam q_t Q_ONE = 48'sd16777216;

    typedef struct {
        q_t rho;
        q_t mx;
        q_t my;
        q_t en;
        q_t rdx;
        q_t rdy;
        q_t mxdx;
        q_t mxdy;
        q_t mydx;
        q_t mydy;
        q_t edx;
        q_t edy;
    } point_t;

    typedef struct {
        q_t   term [NUM_FLUX];
        logic bad;
    } flux_t;

    typedef struct {
        point_t pt;
        bit     typed;
        flux_t  res;
    } row_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    point_t drv;
    logic  cfg_valid;
    logic  cfg_ready;
    cfg_idx_t cfg_index;
    coef_t cfg_data;
    logic  result_valid;
    flux_t got;

    coef_t gamma_m1_model;
    coef_t viscosity_model;
    coef_t heat_coef_model;
    flux_t expected_flux [$];
    row_t  directed_rows [$];
    int    errors;
    int    item_count;

    compressible_ns_point_flux_2d i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .density      (drv.rho),
        .mom_x        (drv.mx),
        .mom_y        (drv.my),
        .total_energy (drv.en),
        .density_dx   (drv.rdx),
        .density_dy   (drv.rdy),
        .mom_x_dx     (drv.mxdx),
        .mom_x_dy     (drv.mxdy),
        .mom_y_dx     (drv.mydx),
        .mom_y_dy     (drv.mydy),
        .energy_dx    (drv.edx),
        .energy_dy    (drv.edy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .inv_xx       (got.term[0]),
        .inv_xy       (got.term[1]),
        .inv_yy       (got.term[2]),
        .inv_energy_x (got.term[3]),
        .inv_energy_y (got.term[4]),
        .stress_xx    (got.term[5]),
        .stress_xy    (got.term[6]),
        .stress_yy    (got.term[7]),
        .vis_energy_x (got.term[8]),
        .vis_energy_y (got.term[9]),
        .bad_density  (got.bad)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Signs and saturates a rounded magnitude.
    function automatic q_t signed_sat(input logic [127:0] m, input logic neg);
        q_t res;
        if (neg)
        begin
            if (m > 128'h8000_0000_0000)
            begin
                res = Q_MIN;
            end
            else
            begin
                res = m[47:0];
                res = -res;
            end
        end
        else if (m > 128'h7FFF_FFFF_FFFF)
        begin
            res = Q_MAX;
        end
        else
        begin
            res = m[47:0];
        end
        return res;
    endfunction

    function automatic q_t q_add(input q_t a, input q_t b);
        logic signed [127:0] s;
        s = 128'(a) + 128'(b);
        if (s > 128'(Q_MAX))
        begin
            return Q_MAX;
        end
        if (s < 128'(Q_MIN))
        begin
            return Q_MIN;
        end
        return q_t'(s);
    endfunction

    function automatic q_t q_sub(input q_t a, input q_t b);
        logic signed [127:0] s;
        s = 128'(a) - 128'(b);
        if (s > 128'(Q_MAX))
        begin
            return Q_MAX;
        end
        if (s < 128'(Q_MIN))
        begin
            return Q_MIN;
        end
        return q_t'(s);
    endfunction

    // Exact product, rounded half away from zero at the binary point.
    function automatic q_t q_mul(input q_t a, input q_t b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] p;
        logic [127:0] m;
        wa = a;
        wb = b;
        p = wa * wb;
        m = (p < 0) ? -p : p;
        m = (m + (128'd1 << 23)) >> 24;
        return signed_sat(m, p < 0);
    endfunction

    // Quotient a / d for a positive divisor, rounded half away from zero.
    function automatic q_t q_div(input q_t a, input q_t d);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] rem;
        num = (a < 0) ? 128'(-128'(a)) : 128'(a);
        num = num << 24;
        den = 128'(d);
        quo = num / den;
        rem = num % den;
        if (rem >= den - rem)
        begin
            quo = quo + 128'd1;
        end
        return signed_sat(quo, a < 0);
    endfunction

    // Inviscid and viscous flux of one point under the current coefficients.
    function automatic flux_t point_flux(input point_t s);
        flux_t f;
        q_t g1, mu, hc;
        q_t u, v, vsq, ke, p, ep, gxx, gxy, gyx, gyy, corr, eint, kgx, kgy, igx, igy;
        g1 = q_t'({16'd0, gamma_m1_model});
        mu = q_t'({16'd0, viscosity_model});
        hc = q_t'({16'd0, heat_coef_model});
        f.bad = 1'b0;
        for (int k = 0; k < NUM_FLUX; k++)
        begin
            f.term[k] = '0;
        end
        if (s.rho <= 0)
        begin
            f.bad = 1'b1;
            return f;
        end
        u = q_div(s.mx, s.rho);
        v = q_div(s.my, s.rho);
        vsq = q_add(q_mul(u, u), q_mul(v, v));
        ke = q_mul(q_mul(Q_HALF, s.rho), vsq);
        p = q_mul(q_sub(s.en, ke), g1);
        ep = q_add(s.en, p);
        f.term[0] = q_add(q_mul(s.mx, u), p);
        f.term[1] = q_mul(s.mx, v);
        f.term[2] = q_add(q_mul(s.my, v), p);
        f.term[3] = q_mul(ep, u);
        f.term[4] = q_mul(ep, v);
        // Velocity gradients from the quotient rule.
        gxx = q_div(q_sub(s.mxdx, q_mul(s.rdx, u)), s.rho);
        gxy = q_div(q_sub(s.mxdy, q_mul(s.rdy, u)), s.rho);
        gyx = q_div(q_sub(s.mydx, q_mul(s.rdx, v)), s.rho);
        gyy = q_div(q_sub(s.mydy, q_mul(s.rdy, v)), s.rho);
        corr = q_mul(q_mul(mu, q_add(gxx, gyy)), Q_TWO_THIRDS);
        f.term[5] = q_sub(q_mul(mu, q_add(gxx, gxx)), corr);
        f.term[6] = q_mul(mu, q_add(gxy, gyx));
        f.term[7] = q_sub(q_mul(mu, q_add(gyy, gyy)), corr);
        // Internal-energy gradient and viscous energy flux.
        eint = q_div(q_sub(s.en, ke), s.rho);
        kgx = q_add(q_mul(Q_HALF, q_mul(vsq, s.rdx)),
                    q_mul(s.rho, q_add(q_mul(gxx, u), q_mul(gyx, v))));
        kgy = q_add(q_mul(Q_HALF, q_mul(vsq, s.rdy)),
                    q_mul(s.rho, q_add(q_mul(gxy, u), q_mul(gyy, v))));
        igx = q_div(q_sub(q_sub(s.edx, kgx), q_mul(s.rdx, eint)), s.rho);
        igy = q_div(q_sub(q_sub(s.edy, kgy), q_mul(s.rdy, eint)), s.rho);
        f.term[8] = q_add(q_mul(hc, igx), q_add(q_mul(u, f.term[5]), q_mul(v, f.term[6])));
        f.term[9] = q_add(q_mul(hc, igy), q_add(q_mul(u, f.term[6]), q_mul(v, f.term[7])));
        return f;
    endfunction

    function automatic point_t fill_point(input q_t rho, input q_t rest);
        point_t s;
        s = '{rest, rest, rest, rest, rest, rest, rest, rest, rest, rest, rest, rest};
        s.rho = rho;
        return s;
    endfunction

    function automatic q_t any_q();
        return q_t'({$urandom, $urandom});
    endfunction

    // Moderate signed value with a random magnitude scale.
    function automatic q_t mild_q(input int max_shift);
        q_t x;
        x = q_t'(signed'($urandom)) >>> $urandom_range(max_shift, 0);
        return x;
    endfunction

    // Mostly physical states, some raw bit patterns, some bad densities.
    function automatic point_t random_point();
        point_t s;
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            s = '{any_q(), any_q(), any_q(), any_q(), any_q(), any_q(),
                  any_q(), any_q(), any_q(), any_q(), any_q(), any_q()};
        end
        else
        begin
            s = '{mild_q(8), mild_q(8), mild_q(8), mild_q(8), mild_q(12), mild_q(12),
                  mild_q(12), mild_q(12), mild_q(12), mild_q(12), mild_q(12), mild_q(12)};
            s.rho = q_t'({16'd0, $urandom}) >> $urandom_range(6, 0);
            s.rho = s.rho + Q_ONE / 16;
            if (s.en < 0)
            begin
                s.en = -s.en;
            end
            if (pick < 35)
            begin
                s.rho = -q_t'($urandom_range(3, 0));
            end
        end
        return s;
    endfunction

    // Sends one point; the expectation enters the store at the accepting edge.
    task automatic send_point(input point_t s, input bit typed, input flux_t res, input bit calm);
        while (!calm && $urandom_range(99) < 27)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        drv <= s;
        start <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        expected_flux.push_back(typed ? res : point_flux(s));
        item_count++;
        @(negedge clk);
    endtask

    task automatic write_coef(input cfg_idx_t idx, input coef_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            REG_GAMMA_M1:  gamma_m1_model = value;
            REG_VISCOSITY: viscosity_model = value;
            REG_HEAT_COEF: heat_coef_model = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_flux.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (PIPE_LAT + 4) @(negedge clk);
    endtask

    task automatic random_phase(input int count);
        for (int k = 0; k < count; k++)
        begin
            send_point(random_point(), 1'b0, '{default: '0},
                       item_count >= QUIET_FIRST && item_count < QUIET_LAST);
        end
        drain();
    endtask

    // Compares every result beat with the oldest expectation.
    always @(posedge clk)
    begin
        flux_t want;
        if (rst_n && result_valid)
        begin
            if (expected_flux.size() == 0)
            begin
                $display("%0t: unexpected result beat", $time);
                errors++;
            end
            else
            begin
                want = expected_flux.pop_front();
                for (int k = 0; k < NUM_FLUX; k++)
                begin
                    if (got.term[k] !== want.term[k])
                    begin
                        $display("%0t: flux term %0d expected %h got %h",
                                 $time, k, want.term[k], got.term[k]);
                        errors++;
                    end
                end
                if (got.bad !== want.bad)
                begin
                    $display("%0t: bad_density expected %b got %b", $time, want.bad, got.bad);
                    errors++;
                end
            end
        end
    end

    // Stimulus and the final verdict.
    initial
    begin
        flux_t zero_flux;
        flux_t bad_flux;
        errors = 0;
        item_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        drv = fill_point('0, '0);
        cfg_valid = 1'b0;
        cfg_index = REG_GAMMA_M1;
        cfg_data = '0;
        gamma_m1_model = GAMMA_M1_RST;
        viscosity_model = VISCOSITY_RST;
        heat_coef_model = HEAT_COEF_RST;
        zero_flux = '{default: '0};
        bad_flux = zero_flux;
        bad_flux.bad = 1'b1;

        // Directed rows: bad densities, a state at rest, extremes, typical flows and random points.
        directed_rows.push_back('{fill_point('0, '0), 1'b1, bad_flux});
        directed_rows.push_back('{fill_point(-48'sd1, Q_ONE), 1'b1, bad_flux});
        directed_rows.push_back('{fill_point(Q_MIN, Q_MAX), 1'b1, bad_flux});
        directed_rows.push_back('{fill_point(Q_MIN, Q_MIN), 1'b1, bad_flux});
        directed_rows.push_back('{fill_point(Q_ONE, '0), 1'b1, zero_flux});
        directed_rows.push_back('{fill_point(Q_ONE, Q_MAX), 1'b0, zero_flux});
        directed_rows.push_back('{fill_point(Q_ONE, Q_MIN), 1'b0, zero_flux});
        directed_rows.push_back('{fill_point(48'sd1, Q_MAX), 1'b0, zero_flux});
        directed_rows.push_back('{fill_point(48'sd1, Q_MIN), 1'b0, zero_flux});
        directed_rows.push_back('{fill_point(48'sd1, 48'sd1), 1'b0, zero_flux});
        directed_rows.push_back('{fill_point(Q_MAX, Q_MAX), 1'b0, zero_flux});
        directed_rows.push_back('{fill_point(Q_MAX, -48'sd1), 1'b0, zero_flux});
        directed_rows.push_back('{fill_point(Q_ONE * 3, Q_ONE), 1'b0, zero_flux});
        directed_rows.push_back('{fill_point(Q_ONE * 2, -Q_ONE / 3), 1'b0, zero_flux});
        directed_rows.push_back('{fill_point(Q_ONE, Q_HALF), 1'b0, zero_flux});
        for (int k = 0; k < 6; k++)
        begin
            directed_rows.push_back('{random_point(), 1'b0, zero_flux});
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset coefficients.
        foreach (directed_rows[k])
        begin
            send_point(directed_rows[k].pt, directed_rows[k].typed, directed_rows[k].res, 1'b0);
        end
        random_phase(190);

        // All coefficients at zero; the unused index must change nothing.
        write_coef(REG_GAMMA_M1, '0);
        write_coef(REG_VISCOSITY, '0);
        write_coef(REG_HEAT_COEF, '0);
        write_coef(REG_NONE, '1);
        random_phase(190);

        // All coefficients at their maximum.
        write_coef(REG_GAMMA_M1, '1);
        write_coef(REG_VISCOSITY, '1);
        write_coef(REG_HEAT_COEF, '1);
        random_phase(190);

        // Air-like values.
        write_coef(REG_GAMMA_M1, 32'd6710886);
        write_coef(REG_VISCOSITY, 32'd16777216);
        write_coef(REG_HEAT_COEF, 32'd8388608);
        random_phase(190);

        for (int phase = 0; phase < 2; phase++)
        begin
            write_coef(REG_GAMMA_M1, $urandom);
            write_coef(REG_VISCOSITY, $urandom >> $urandom_range(31, 0));
            write_coef(REG_HEAT_COEF, $urandom >> $urandom_range(31, 0));
            random_phase(195);
        end

        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #8000000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/cnsf_pkg.sv
rtl/core/cnsf_dly.sv
rtl/core/cnsf_add.sv
rtl/core/cnsf_mul.sv
rtl/core/cnsf_div.sv
rtl/core/compressible_ns_point_flux_2d.sv
rtl/core/cnsf_chk.sv
verif/compressible_ns_point_flux_2d_tb.sv
